[sv/docc_pkg.sv]
// Shared types, constants and legend decode for the depth ordered circle cover unit.
package docc_pkg;

  // Table depth default and fixed canvas size
  localparam int DEF_MAX_CIRCLES = 32;
  localparam int CANVAS_WIDTH    = 128;
  localparam int CANVAS_HEIGHT   = 64;

  // Item modes
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  // Color codes kept in the collected sequence
  localparam logic [1:0] COL_R   = 2'd0;
  localparam logic [1:0] COL_G   = 2'd1;
  localparam logic [1:0] COL_B   = 2'd2;
  localparam logic [1:0] COL_BAD = 2'd3;

  // Legend characters (7-bit ASCII)
  localparam logic [6:0] CH_NONE = 7'h00;
  localparam logic [6:0] CH_DOT  = 7'h2E;
  localparam logic [6:0] CH_1    = 7'h31;
  localparam logic [6:0] CH_2    = 7'h32;
  localparam logic [6:0] CH_3    = 7'h33;
  localparam logic [6:0] CH_4    = 7'h34;
  localparam logic [6:0] CH_5    = 7'h35;
  localparam logic [6:0] CH_6    = 7'h36;
  localparam logic [6:0] CH_7    = 7'h37;
  localparam logic [6:0] CH_8    = 7'h38;
  localparam logic [6:0] CH_9    = 7'h39;
  localparam logic [6:0] CH_A    = 7'h41;
  localparam logic [6:0] CH_B    = 7'h42;
  localparam logic [6:0] CH_C    = 7'h43;
  localparam logic [6:0] CH_G    = 7'h47;
  localparam logic [6:0] CH_R    = 7'h52;

  // Paint bytes that are recognized
  localparam logic [7:0] PAINT_R = 8'h52;
  localparam logic [7:0] PAINT_G = 8'h47;
  localparam logic [7:0] PAINT_B = 8'h42;

  // Squarer operand and result widths
  localparam int OP_W = 13;
  localparam int SQ_W = 2 * OP_W;

  // One table entry
  typedef struct packed {
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic        [15:0] dep;
    logic        [10:0] rad;
    logic        [7:0]  color;
  } entry_t;

  // Paint byte to color code
  function automatic logic [1:0] color_code(logic [7:0] paint);
    logic [1:0] code;
    case (paint)
      PAINT_R: code = COL_R;
      PAINT_G: code = COL_G;
      PAINT_B: code = COL_B;
      default: code = COL_BAD;
    endcase
    return code;
  endfunction

  // Sequence of one to three valid codes to legend character
  function automatic logic [6:0] legend(logic [1:0] n, logic [1:0] c0, logic [1:0] c1,
                                        logic [1:0] c2);
    logic [6:0] ch;
    ch = CH_DOT;
    case (n)
      2'd1: begin
        case (c0)
          COL_R:   ch = CH_R;
          COL_G:   ch = CH_G;
          default: ch = CH_B;
        endcase
      end
      2'd2: begin
        case ({c0, c1})
          {COL_R, COL_G}: ch = CH_1;
          {COL_R, COL_B}: ch = CH_2;
          {COL_G, COL_B}: ch = CH_3;
          {COL_G, COL_R}: ch = CH_4;
          {COL_B, COL_R}: ch = CH_5;
          {COL_B, COL_G}: ch = CH_6;
          default:        ch = CH_DOT;
        endcase
      end
      2'd3: begin
        if (c0 == c1 || c0 == c2 || c1 == c2) begin
          ch = CH_DOT;
        end else if (c0 == COL_R) begin
          ch = (c1 == COL_G) ? CH_7 : CH_8;
        end else if (c0 == COL_G) begin
          ch = (c1 == COL_R) ? CH_9 : CH_A;
        end else begin
          ch = (c1 == COL_R) ? CH_B : CH_C;
        end
      end
      default: ch = CH_DOT;
    endcase
    return ch;
  endfunction

endpackage

[sv/docc_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface docc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [11:0] center_x;
  logic signed [11:0] center_y;
  logic [15:0]        depth;
  logic [10:0]        rad;
  logic [7:0]         paint;
  logic [6:0]         pixel_x;
  logic [5:0]         pixel_y;

  modport source (output valid, mode, center_x, center_y, depth, rad, paint, pixel_x,
                  pixel_y, input ready);
  modport sink (input valid, mode, center_x, center_y, depth, rad, paint, pixel_x,
                pixel_y, output ready);
endinterface

interface docc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol;
  logic       rejected;
  logic [5:0] circles_held;

  modport source (output valid, symbol, rejected, circles_held, input ready);
  modport sink (input valid, symbol, rejected, circles_held, output ready);
endinterface

[sv/depth_ordered_circle_cover_unit.sv]
// Depth sorted circle table with a per-pixel cover query, one item at a time.
// Load: entries shift up until the new depth fits; a full table is rejected.
// Query: three passes per stored circle through the one shared squarer; clear empties it.
// A new item is taken once the previous one has moved into the output register.
// Reset empties the table (count zero); table memory contents are not cleared.
module depth_ordered_circle_cover_unit #(
  parameter int MAX_CIRCLES = docc_pkg::DEF_MAX_CIRCLES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  docc_in_if.sink      in_i,
  docc_out_if.source   out_o
);

  localparam int IW = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
  localparam int CW = $clog2(MAX_CIRCLES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_PUT,
    S_QRY_WALK,
    S_EMIT
  } state_e;

  state_e                   state_q;
  logic [CW-1:0]            cnt_q;
  logic [CW-1:0]            k_q;
  logic [CW-1:0]            i_q;
  logic [1:0]               phase_q;
  logic [1:0]               n_q;
  logic                     bad_q;
  logic [1:0]               seq0_q, seq1_q, seq2_q;
  logic [1:0]               mode_q;
  logic                     rej_q;
  docc_pkg::entry_t         new_q;
  logic [6:0]               px_q;
  logic [5:0]               py_q;
  logic [docc_pkg::SQ_W-1:0] acc_q;

  logic                     out_valid_q;
  logic [6:0]               out_sym_q;
  logic                     out_rej_q;
  logic [5:0]               out_held_q;

  // Table memory, one write and one registered read port
  docc_pkg::entry_t         mem_q [MAX_CIRCLES];
  docc_pkg::entry_t         rd_q;
  logic                     mem_we, mem_re;
  logic [IW-1:0]            mem_waddr, mem_raddr;
  docc_pkg::entry_t         mem_wdata;

  logic                     in_fire;
  logic                     emit_go;
  logic                     outside;
  logic                     full;
  logic [CW-1:0]            cnt_m1, k_m1, k_m2, i_p1;
  logic                     ins_here;
  logic                     last;
  logic signed [docc_pkg::OP_W-1:0] op;
  logic signed [docc_pkg::SQ_W-1:0] sq_full;
  logic [docc_pkg::SQ_W-1:0] sq;
  logic                     cov;
  logic [1:0]               code;
  logic [6:0]               sym;

  assign in_fire  = in_i.valid && (state_q == S_IDLE);
  assign emit_go  = (state_q == S_EMIT) && (!out_valid_q || out_o.ready);
  assign outside  = (13'(in_i.pixel_x) >= 13'(docc_pkg::CANVAS_WIDTH)) ||
                    (13'(in_i.pixel_y) >= 13'(docc_pkg::CANVAS_HEIGHT));
  assign full     = (cnt_q == CW'(MAX_CIRCLES));
  assign cnt_m1   = cnt_q - CW'(1);
  assign k_m1     = k_q - CW'(1);
  assign k_m2     = k_q - CW'(2);
  assign i_p1     = i_q + CW'(1);
  assign ins_here = (rd_q.dep >= new_q.dep);
  assign last     = (i_p1 == cnt_q);

  // Shared squarer: dx, dy, then radius over the three phases of one entry
  always_comb begin
    case (phase_q)
      2'd0:    op = $signed({6'b0, px_q}) - $signed({rd_q.cx[11], rd_q.cx});
      2'd1:    op = $signed({7'b0, py_q}) - $signed({rd_q.cy[11], rd_q.cy});
      default: op = $signed({2'b0, rd_q.rad});
    endcase
  end

  assign sq_full = op * op;
  assign sq      = sq_full;
  assign cov     = (acc_q <= sq);
  assign code    = docc_pkg::color_code(rd_q.color);

  // Result character of the finished item
  always_comb begin
    if (mode_q != docc_pkg::MODE_QUERY) begin
      sym = docc_pkg::CH_NONE;
    end else if (bad_q || n_q == 2'd0) begin
      sym = docc_pkg::CH_DOT;
    end else begin
      sym = docc_pkg::legend(n_q, seq0_q, seq1_q, seq2_q);
    end
  end

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_q[IW-1:0];
    mem_wdata = new_q;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_i.mode == docc_pkg::MODE_LOAD && !full && cnt_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_m1[IW-1:0];
        end else if (in_fire && in_i.mode == docc_pkg::MODE_QUERY && !outside &&
                     cnt_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
        end
      end
      S_INS_WALK: begin
        mem_we    = 1'b1;
        mem_wdata = ins_here ? new_q : rd_q;
        if (!ins_here && k_q != CW'(1)) begin
          mem_re    = 1'b1;
          mem_raddr = k_m2[IW-1:0];
        end
      end
      S_INS_PUT: begin
        mem_we = 1'b1;
      end
      S_QRY_WALK: begin
        if (phase_q == 2'd2 && !last) begin
          mem_re    = 1'b1;
          mem_raddr = i_p1[IW-1:0];
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      i_q         <= '0;
      phase_q     <= 2'd0;
      n_q         <= 2'd0;
      bad_q       <= 1'b0;
      seq0_q      <= docc_pkg::COL_R;
      seq1_q      <= docc_pkg::COL_R;
      seq2_q      <= docc_pkg::COL_R;
      mode_q      <= docc_pkg::MODE_LOAD;
      rej_q       <= 1'b0;
      new_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_sym_q   <= '0;
      out_rej_q   <= 1'b0;
      out_held_q  <= '0;
    end else begin
      if (out_valid_q && out_o.ready && !emit_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            mode_q    <= in_i.mode;
            new_q.cx  <= in_i.center_x;
            new_q.cy  <= in_i.center_y;
            new_q.dep <= in_i.depth;
            new_q.rad <= in_i.rad;
            new_q.color <= in_i.paint;
            px_q      <= in_i.pixel_x;
            py_q      <= in_i.pixel_y;
            rej_q     <= (in_i.mode == docc_pkg::MODE_LOAD) && full;
            n_q       <= 2'd0;
            bad_q     <= (in_i.mode == docc_pkg::MODE_QUERY) && outside;
            phase_q   <= 2'd0;
            i_q       <= '0;
            k_q       <= cnt_q;
            case (in_i.mode)
              docc_pkg::MODE_LOAD: begin
                if (full) begin
                  state_q <= S_EMIT;
                end else if (cnt_q == '0) begin
                  state_q <= S_INS_PUT;
                end else begin
                  state_q <= S_INS_WALK;
                end
              end
              docc_pkg::MODE_QUERY: begin
                if (outside || cnt_q == '0) begin
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_QRY_WALK;
                end
              end
              docc_pkg::MODE_CLEAR: begin
                cnt_q   <= '0;
                state_q <= S_EMIT;
              end
              default: begin
                state_q <= S_EMIT;
              end
            endcase
          end
        end
        // Shift entries up until the new depth fits
        S_INS_WALK: begin
          if (ins_here) begin
            cnt_q   <= cnt_q + CW'(1);
            state_q <= S_EMIT;
          end else if (k_q == CW'(1)) begin
            k_q     <= '0;
            state_q <= S_INS_PUT;
          end else begin
            k_q <= k_m1;
          end
        end
        S_INS_PUT: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= S_EMIT;
        end
        // Three squarer passes per entry, then collect its color
        S_QRY_WALK: begin
          case (phase_q)
            2'd0: begin
              acc_q   <= sq;
              phase_q <= 2'd1;
            end
            2'd1: begin
              acc_q   <= acc_q + sq;
              phase_q <= 2'd2;
            end
            default: begin
              if (cov) begin
                if (n_q == 2'd3) begin
                  bad_q <= 1'b1;
                end else begin
                  case (n_q)
                    2'd0:    seq0_q <= code;
                    2'd1:    seq1_q <= code;
                    default: seq2_q <= code;
                  endcase
                  if (code == docc_pkg::COL_BAD) begin
                    bad_q <= 1'b1;
                  end
                  n_q <= n_q + 2'd1;
                end
              end
              phase_q <= 2'd0;
              if (last) begin
                state_q <= S_EMIT;
              end else begin
                i_q <= i_p1;
              end
            end
          endcase
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            out_sym_q   <= sym;
            out_rej_q   <= rej_q;
            out_held_q  <= 6'(cnt_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.symbol       = out_sym_q;
  assign out_o.rejected     = out_rej_q;
  assign out_o.circles_held = out_held_q;

endmodule
